### sv/lfsp_pkg.sv
package lfsp_pkg;

  // Field widths
  localparam int unsigned ErrW      = 16;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned DriveW    = 10;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SumW      = 32;
  localparam int unsigned DiffW     = 17;
  localparam int unsigned GlitchW   = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaxErrW   = 15;

  // Shared multiplier: 16-bit gain by 33-bit operand, 49-bit product
  localparam int unsigned MulAW     = 16;
  localparam int unsigned MulBW     = 33;
  localparam int unsigned ProdW     = MulAW + MulBW;

  // Drive arithmetic width (numerator in units of 1/655360)
  localparam int unsigned NumW      = 56;

  localparam int unsigned GLITCH_LIMIT_DEF = 5;

  // Glitch threshold, 99.0 in Q8.8
  localparam logic signed [ErrW-1:0] GLITCH_LEVEL_C = 16'sd25344;
  localparam logic [GlitchW-1:0]     GLITCH_MAX_C   = 3'd7;

  // Quotient saturation point: 256 * 10 in units of 1/10 of speed
  localparam logic [11:0] DIV_SAT_C   = 12'd2560;
  localparam logic [12:0] RECIP_TEN_C = 13'd6554;

  // Status codes
  localparam logic [StatusW-1:0] STAT_STEER_C = 2'd0;
  localparam logic [StatusW-1:0] STAT_HOLD_C  = 2'd1;
  localparam logic [StatusW-1:0] STAT_STOP_C  = 2'd2;

  // Configuration register indices
  localparam logic [CfgIdxW-1:0] CFG_MODE_C      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P_C    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I_C    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D_C    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED_C = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ERROR_C = 3'd5;

  // Steering table error points, Q8.8
  localparam logic signed [ErrW-1:0] TBL_POS_HALF_C  = 16'sd128;
  localparam logic signed [ErrW-1:0] TBL_NEG_HALF_C  = -16'sd128;
  localparam logic signed [ErrW-1:0] TBL_POS_ONE_C   = 16'sd256;
  localparam logic signed [ErrW-1:0] TBL_NEG_ONE_C   = -16'sd256;
  localparam logic signed [ErrW-1:0] TBL_POS_ONE5_C  = 16'sd384;
  localparam logic signed [ErrW-1:0] TBL_NEG_ONE5_C  = -16'sd384;
  localparam logic signed [ErrW-1:0] TBL_POS_TWO_C   = 16'sd512;
  localparam logic signed [ErrW-1:0] TBL_NEG_TWO_C   = -16'sd512;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_SCALE,
    ST_NUM,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                     en;
    logic signed [MulAW-1:0]  a;
    logic signed [MulBW-1:0]  b;
  } mul_req_t;

  // floor(2s/3) via multiplication by 683/2048, exact for s below 256
  function automatic logic [SpeedW-1:0] two_thirds(input logic [SpeedW-1:0] s);
    logic [19:0] p;
    p = {11'b0, s, 1'b0} * 20'd683;
    return p[18:11];
  endfunction

  // floor(13s/10) via multiplication by 6554/65536, exact for s below 256
  function automatic logic [8:0] thirteen_tenths(input logic [SpeedW-1:0] s);
    logic [11:0] x;
    logic [24:0] p;
    x = {4'b0, s} * 12'd13;
    p = {13'b0, x} * {12'b0, RECIP_TEN_C};
    return p[24:16];
  endfunction

endpackage

### sv/lfsp_mul.sv
module lfsp_mul (
  input  logic                                  clk_i,
  input  lfsp_pkg::mul_req_t                    req_i,
  output logic signed [lfsp_pkg::ProdW-1:0]     prod_o
);

  logic signed [lfsp_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

### sv/line_follow_steering_pid.sv
// Line follower steering: PID or table mode, one request at a time.
// Glitch and table requests go from idle straight to the done state; PID requests
// make three multiplier passes, an accumulate and four steps per wheel.
// A new request is taken only in idle, after the last result has gone to the output
// register; a stalled result keeps the next one in its final state.
// Reset clears the error sum, previous error, glitch count, output valid and state; config takes its defaults.
module line_follow_steering_pid #(
  parameter int unsigned GLITCH_LIMIT = lfsp_pkg::GLITCH_LIMIT_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lfsp_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [lfsp_pkg::CfgDataW-1:0]          cfg_data_i,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [lfsp_pkg::ErrW-1:0]       line_error_i,
  input  logic [lfsp_pkg::SpeedW-1:0]            base_speed_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lfsp_pkg::DriveW-1:0]     left_drive_o,
  output logic signed [lfsp_pkg::DriveW-1:0]     right_drive_o,
  output logic [lfsp_pkg::StatusW-1:0]           status_o
);

  localparam int unsigned ErrW   = lfsp_pkg::ErrW;
  localparam int unsigned SpeedW = lfsp_pkg::SpeedW;
  localparam int unsigned DriveW = lfsp_pkg::DriveW;
  localparam int unsigned NumW   = lfsp_pkg::NumW;
  localparam int unsigned ProdW  = lfsp_pkg::ProdW;
  localparam int unsigned SumW   = lfsp_pkg::SumW;
  localparam int unsigned DiffW  = lfsp_pkg::DiffW;
  localparam int unsigned GlW    = lfsp_pkg::GlitchW;

  // Configuration registers
  logic                               mode_q;
  logic signed [15:0]                 gain_p_q, gain_i_q, gain_d_q;
  logic [SpeedW-1:0]                  max_speed_q;
  logic [lfsp_pkg::MaxErrW-1:0]       max_error_q;

  // Control state
  lfsp_pkg::state_e                   state_q, state_d;
  logic                               wheel_q, wheel_d;
  logic [GlW-1:0]                     glitch_cnt_q, glitch_cnt_d;
  logic signed [SumW-1:0]             error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]             prev_err_q, prev_err_d;
  logic                               out_valid_q, out_valid_d;

  // Working payload
  logic signed [ErrW-1:0]             e_q, e_d;
  logic [SpeedW-1:0]                  s_q, s_d;
  logic signed [DiffW-1:0]            diff_q, diff_d;
  logic signed [ProdW-1:0]            acc_q, acc_d;
  logic signed [NumW-1:0]             kc_q, kc_d;
  logic signed [NumW-1:0]             num_q, num_d;
  logic                               neg_q, neg_d;
  logic                               big_q, big_d;
  logic [11:0]                        mq_q, mq_d;
  logic signed [DriveW-1:0]           res_left_q, res_left_d;
  logic signed [DriveW-1:0]           res_right_q, res_right_d;
  logic [lfsp_pkg::StatusW-1:0]       res_status_q, res_status_d;

  // Output register
  logic signed [DriveW-1:0]           out_left_q, out_right_q;
  logic [lfsp_pkg::StatusW-1:0]       out_status_q;
  logic                               out_load;

  // Shared multiplier
  lfsp_pkg::mul_req_t                 mul_req;
  logic signed [ProdW-1:0]            prod;

  // Combinational helpers
  logic [GlW-1:0]                     glitch_inc;
  logic signed [SumW:0]               sum_ext;
  logic [ErrW-1:0]                    err_mag;
  logic signed [ErrW-1:0]             tbl_err;
  logic [SpeedW-1:0]                  s_two3;
  logic [8:0]                         s_13_10;
  logic signed [NumW-1:0]             c_ext;
  logic                               use35;
  logic [11:0]                        s_ten;
  logic signed [NumW-1:0]             s_scaled;
  logic [NumW-1:0]                    num_mag;
  logic [24:0]                        q_prod;
  logic [SpeedW-1:0]                  q_raw, q_clamp;
  logic signed [DriveW-1:0]           q_signed;
  logic signed [DriveW-1:0]           s_drive;

  lfsp_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      gain_p_q    <= 16'sd256;
      gain_i_q    <= 16'sd0;
      gain_d_q    <= 16'sd0;
      max_speed_q <= 8'd255;
      max_error_q <= 15'd512;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lfsp_pkg::CFG_MODE_C:      mode_q      <= cfg_data_i[0];
        lfsp_pkg::CFG_GAIN_P_C:    gain_p_q    <= cfg_data_i;
        lfsp_pkg::CFG_GAIN_I_C:    gain_i_q    <= cfg_data_i;
        lfsp_pkg::CFG_GAIN_D_C:    gain_d_q    <= cfg_data_i;
        lfsp_pkg::CFG_MAX_SPEED_C: max_speed_q <= cfg_data_i[SpeedW-1:0];
        lfsp_pkg::CFG_MAX_ERROR_C: max_error_q <= cfg_data_i[lfsp_pkg::MaxErrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lfsp_pkg::ST_IDLE;
      wheel_q      <= 1'b0;
      glitch_cnt_q <= '0;
      error_sum_q  <= '0;
      prev_err_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wheel_q      <= wheel_d;
      glitch_cnt_q <= glitch_cnt_d;
      error_sum_q  <= error_sum_d;
      prev_err_q   <= prev_err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q          <= e_d;
    s_q          <= s_d;
    diff_q       <= diff_d;
    acc_q        <= acc_d;
    kc_q         <= kc_d;
    num_q        <= num_d;
    neg_q        <= neg_d;
    big_q        <= big_d;
    mq_q         <= mq_d;
    res_left_q   <= res_left_d;
    res_right_q  <= res_right_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_left_q   <= res_left_q;
      out_right_q  <= res_right_q;
      out_status_q <= res_status_q;
    end
  end

  always_comb begin
    // Request-side helpers
    glitch_inc = (glitch_cnt_q == lfsp_pkg::GLITCH_MAX_C) ? glitch_cnt_q
                                                          : glitch_cnt_q + 1'b1;
    sum_ext = {error_sum_q[SumW-1], error_sum_q}
            + {{(SumW+1-ErrW){line_error_i[ErrW-1]}}, line_error_i};
    err_mag = line_error_i[ErrW-1] ? (~line_error_i + 1'b1) : line_error_i;
    tbl_err = (err_mag > {1'b0, max_error_q}) ? prev_err_q : line_error_i;
    s_two3  = lfsp_pkg::two_thirds(base_speed_i);
    s_13_10 = lfsp_pkg::thirteen_tenths(base_speed_i);
    s_drive = {2'b00, base_speed_i};

    // Drive helpers
    c_ext    = {{(NumW-ProdW){acc_q[ProdW-1]}}, acc_q};
    // The larger factor applies to the left wheel for a positive correction
    use35    = wheel_q ? (acc_q <= 0) : (acc_q > 0);
    s_ten    = ({4'b0, s_q} << 3) + ({4'b0, s_q} << 1);
    s_scaled = {{(NumW-28){1'b0}}, s_ten, 16'b0};
    num_mag  = num_q[NumW-1] ? (~num_q + 1'b1) : num_q;
    q_prod   = {13'b0, mq_q} * {12'b0, lfsp_pkg::RECIP_TEN_C};
    q_raw    = q_prod[23:16];
    q_clamp  = (big_q || (q_raw > max_speed_q)) ? max_speed_q : q_raw;
    q_signed = neg_q ? -{2'b00, q_clamp} : {2'b00, q_clamp};

    state_d      = state_q;
    wheel_d      = wheel_q;
    glitch_cnt_d = glitch_cnt_q;
    error_sum_d  = error_sum_q;
    prev_err_d   = prev_err_q;
    e_d          = e_q;
    s_d          = s_q;
    diff_d       = diff_q;
    acc_d        = acc_q;
    kc_d         = kc_q;
    num_d        = num_q;
    neg_d        = neg_q;
    big_d        = big_q;
    mq_d         = mq_q;
    res_left_d   = res_left_q;
    res_right_d  = res_right_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    mul_req.en   = 1'b0;
    mul_req.a    = gain_p_q;
    mul_req.b    = {{(lfsp_pkg::MulBW-ErrW){e_q[ErrW-1]}}, e_q};

    case (state_q)
      lfsp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          e_d = line_error_i;
          s_d = base_speed_i;
          if (line_error_i >= lfsp_pkg::GLITCH_LEVEL_C) begin
            glitch_cnt_d = glitch_inc;
            if (glitch_inc > GlW'(GLITCH_LIMIT)) begin
              res_left_d   = '0;
              res_right_d  = '0;
              res_status_d = lfsp_pkg::STAT_STOP_C;
            end else begin
              res_left_d   = s_drive;
              res_right_d  = s_drive;
              res_status_d = lfsp_pkg::STAT_HOLD_C;
            end
            state_d = lfsp_pkg::ST_DONE;
          end else if (mode_q) begin
            glitch_cnt_d = '0;
            prev_err_d   = tbl_err;
            res_left_d   = s_drive;
            res_right_d  = s_drive;
            res_status_d = lfsp_pkg::STAT_STEER_C;
            case (tbl_err)
              lfsp_pkg::TBL_POS_HALF_C: res_left_d  = {2'b00, s_two3};
              lfsp_pkg::TBL_NEG_HALF_C: res_right_d = {2'b00, s_two3};
              lfsp_pkg::TBL_POS_ONE_C:  res_left_d  = '0;
              lfsp_pkg::TBL_NEG_ONE_C:  res_right_d = '0;
              lfsp_pkg::TBL_POS_ONE5_C: res_left_d  = -{3'b000, base_speed_i[7:1]};
              lfsp_pkg::TBL_NEG_ONE5_C: res_right_d = -{3'b000, base_speed_i[7:1]};
              lfsp_pkg::TBL_POS_TWO_C:  res_left_d  = -{1'b0, s_13_10};
              lfsp_pkg::TBL_NEG_TWO_C:  res_right_d = -{1'b0, s_13_10};
              default: ;
            endcase
            state_d = lfsp_pkg::ST_DONE;
          end else begin
            glitch_cnt_d = '0;
            // The sum saturates when its two top bits disagree
            if (sum_ext[SumW] != sum_ext[SumW-1]) begin
              error_sum_d = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}}
                                          : {1'b0, {(SumW-1){1'b1}}};
            end else begin
              error_sum_d = sum_ext[SumW-1:0];
            end
            diff_d       = {line_error_i[ErrW-1], line_error_i}
                         - {prev_err_q[ErrW-1], prev_err_q};
            prev_err_d   = line_error_i;
            res_status_d = lfsp_pkg::STAT_STEER_C;
            state_d      = lfsp_pkg::ST_MUL_P;
          end
        end
      end
      lfsp_pkg::ST_MUL_P: begin
        mul_req.en = 1'b1;
        state_d    = lfsp_pkg::ST_MUL_I;
      end
      lfsp_pkg::ST_MUL_I: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_i_q;
        mul_req.b  = {error_sum_q[SumW-1], error_sum_q};
        acc_d      = prod;
        state_d    = lfsp_pkg::ST_MUL_D;
      end
      lfsp_pkg::ST_MUL_D: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_d_q;
        mul_req.b  = {{(lfsp_pkg::MulBW-DiffW){diff_q[DiffW-1]}}, diff_q};
        acc_d      = acc_q + prod;
        state_d    = lfsp_pkg::ST_ACC;
      end
      lfsp_pkg::ST_ACC: begin
        acc_d   = acc_q + prod;
        wheel_d = 1'b0;
        state_d = lfsp_pkg::ST_SCALE;
      end
      lfsp_pkg::ST_SCALE: begin
        // 35c or 7c, both in units of 1/655360 against the Q.16 correction
        kc_d    = use35 ? ((c_ext <<< 5) + (c_ext <<< 1) + c_ext)
                        : ((c_ext <<< 3) - c_ext);
        state_d = lfsp_pkg::ST_NUM;
      end
      lfsp_pkg::ST_NUM: begin
        num_d   = wheel_q ? (s_scaled + kc_q) : (s_scaled - kc_q);
        state_d = lfsp_pkg::ST_ABS;
      end
      lfsp_pkg::ST_ABS: begin
        neg_d   = num_q[NumW-1];
        big_d   = (|num_mag[NumW-1:28]) || (num_mag[27:16] >= lfsp_pkg::DIV_SAT_C);
        mq_d    = num_mag[27:16];
        state_d = lfsp_pkg::ST_DIV;
      end
      lfsp_pkg::ST_DIV: begin
        if (wheel_q) begin
          res_right_d = q_signed;
          state_d     = lfsp_pkg::ST_DONE;
        end else begin
          res_left_d = q_signed;
          wheel_d    = 1'b1;
          state_d    = lfsp_pkg::ST_SCALE;
        end
      end
      lfsp_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = lfsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfsp_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o    = (state_q != lfsp_pkg::ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = out_left_q;
  assign right_drive_o = out_right_q;
  assign status_o      = out_status_q;

endmodule
